// ----- hw/rtl/hpq_pkg.sv -----
// Package for the binary min-heap priority queue.
// Holds the transaction types, command and status codes, and the sequencer states.
// Has no dependencies.
package hpq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OCC_W     = 7;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] data_in;
    logic signed [31:0] prio_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]      data_out;
    logic                    data_valid;
    logic        [1:0]       status;
    logic        [OCC_W-1:0] occupancy;
    logic                    is_empty;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] data;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DQ_ROOT,
    ST_DQ_LAST,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_FIN
  } state_t;

endpackage

// ----- hw/rtl/hpq_ram.sv -----
// Heap entry storage: one write port and one read port with registered read data.
// Depends on hpq_pkg for the entry type.
module hpq_ram import hpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/binary_min_heap_priority_queue_core.sv -----
// Bounded min-priority queue kept as an array binary heap in one synchronous RAM.
// One transaction is processed at a time. An enqueue climbs from the new last slot towards
// the root, one parent read and compare per level; a dequeue moves the last entry to the root
// and sifts it down, fetching the left and right child in turn through the single read port.
// A peek, a dequeue of the last entry, an underflow or an overflow needs no sift.
// A new transaction is taken while the previous result waits in the output register.
// Depends on hpq_pkg and hpq_ram.
module binary_min_heap_priority_queue_core import hpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  entry_t          cur_r, cur_nxt;
  entry_t          lval_r, lval_nxt;
  out_item_t       res_r, res_nxt;
  out_item_t       out_item_r;
  out_item_t       out_load_item;
  logic            out_valid_r;
  logic            out_load;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;

  logic [IW-1:0]   l_idx;
  logic [IW-1:0]   r_idx;
  logic [IW-1:0]   cnt_ext;
  logic [AW-1:0]   parent;
  logic            r_ok;
  logic            take_l;
  logic            take_r;

  hpq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign l_idx   = {1'b0, pos_r, 1'b1};
  assign r_idx   = l_idx + IW'(1);
  assign cnt_ext = IW'(count_r);
  assign parent  = (pos_r - AW'(1)) >> 1;
  assign r_ok    = r_idx < cnt_ext;
  assign take_l  = lval_r.prio < cur_r.prio;
  assign take_r  = r_ok && (take_l ? (mem_rdata.prio < lval_r.prio)
                                   : (mem_rdata.prio < cur_r.prio));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cmd_r  <= cmd_nxt;
    cur_r  <= cur_nxt;
    lval_r <= lval_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    cur_nxt   = cur_r;
    lval_nxt  = lval_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = cur_r;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_item.cmd;
          res_nxt        = '0;
          res_nxt.status = STAT_OK;
          case (in_item.cmd)
            CMD_ENQ: begin
              if (count_r == CW'(DEPTH)) begin
                res_nxt.status = STAT_OVER;
                state_nxt      = ST_FIN;
              end else begin
                cur_nxt.prio = in_item.prio_in;
                cur_nxt.data = in_item.data_in;
                pos_nxt      = count_r[AW-1:0];
                count_nxt    = count_r + CW'(1);
                state_nxt    = ST_UP_RD;
              end
            end
            CMD_DEQ, CMD_PEEK: begin
              if (count_r == '0) begin
                res_nxt.status = STAT_UNDER;
                state_nxt      = ST_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = ST_DQ_ROOT;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata.prio > cur_r.prio) begin
          mem_wdata = mem_rdata;
          pos_nxt   = parent;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DQ_ROOT: begin
        res_nxt.data_out   = mem_rdata.data;
        res_nxt.data_valid = 1'b1;
        if (cmd_r == CMD_PEEK) begin
          state_nxt = ST_FIN;
        end else begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_FIN;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_r - CW'(1));
            state_nxt = ST_DQ_LAST;
          end
        end
      end
      ST_DQ_LAST: begin
        cur_nxt   = mem_rdata;
        pos_nxt   = '0;
        state_nxt = ST_DN_L;
      end
      ST_DN_L: begin
        if (l_idx >= cnt_ext) begin
          mem_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = l_idx[AW-1:0];
          state_nxt = ST_DN_R;
        end
      end
      ST_DN_R: begin
        lval_nxt = mem_rdata;
        if (r_ok) begin
          mem_re    = 1'b1;
          mem_raddr = r_idx[AW-1:0];
        end
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = mem_rdata;
          pos_nxt   = r_idx[AW-1:0];
          state_nxt = ST_DN_L;
        end else if (take_l) begin
          mem_wdata = lval_r;
          pos_nxt   = l_idx[AW-1:0];
          state_nxt = ST_DN_L;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_load_item           = res_r;
    out_load_item.occupancy = OCC_W'(count_r);
    out_load_item.is_empty  = (count_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_load_item;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds the heap depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("heap RAM read and write hit the same entry");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.data_valid) |-> (out_item_r.status == STAT_OK))
    else $error("returned data carries an error status");

  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP_CMP) |-> (pos_r != '0))
    else $error("sift-up compare entered at the root");

  a_dn_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DN_CMP) |-> ($past(state_r) == ST_DN_R))
    else $error("sift-down compare without child fetch");

endmodule
